@@ rtl/rcpsd_pkg.sv @@
// rcpsd_pkg: types and constants shared by the rc pulse switch demux
// no dependencies; compile first

package rcpsd_pkg;

   localparam int PULSE_W   = 14;
   localparam int CSR_IDX_W = 3;
   localparam int SEG_W     = 12;   // signed segment width, |seg| <= 16383/11
   localparam int VAL_W     = 18;   // signed working width for mix compares

   localparam int NUM_MULT  = 16;   // thresholds 0*seg .. 15*seg

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_DEMUX_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AUTOPILOT_AVAIL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SWITCH_THRESH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_MIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_MAX      = 3'd4;

   typedef enum logic [1:0] {
      MODE_TWO_POS   = 2'd0,
      MODE_THREE_POS = 2'd1,
      MODE_MIX_223   = 2'd2,
      MODE_MIX_224   = 2'd3
   } mode_type;

   localparam logic [PULSE_W-1:0] LOW_LIMIT       = 14'd1300;
   localparam logic [PULSE_W-1:0] HIGH_LIMIT      = 14'd1700;
   localparam logic [PULSE_W:0]   FAILSAFE_MARGIN = 15'd100;

   localparam int SEGS_223 = 12;
   localparam int SEGS_224 = 16;

   // reciprocal multiply for span / (segs - 1), exact for |span| < 2**14
   localparam int SHIFT_223 = 21;
   localparam int SHIFT_224 = 22;
   localparam int RECIP_223 = (2 ** SHIFT_223) / (SEGS_223 - 1) + 1;
   localparam int RECIP_224 = (2 ** SHIFT_224) / (SEGS_224 - 1) + 1;

   localparam logic [PULSE_W-1:0] RST_SWITCH_THRESH = 14'd1500;
   localparam logic [PULSE_W-1:0] RST_PULSE_MIN     = 14'd1000;
   localparam logic [PULSE_W-1:0] RST_PULSE_MAX     = 14'd2000;
   localparam int RST_SEG_223 = (2000 - 1000) / (SEGS_223 - 1);
   localparam int RST_SEG_224 = (2000 - 1000) / (SEGS_224 - 1);

   typedef struct packed {
      mode_type                 demux_mode;
      logic                     autopilot_available;
      logic [PULSE_W-1:0]       switch_threshold;
      logic [PULSE_W-1:0]       pulse_min;
      logic [PULSE_W-1:0]       pulse_max;
      logic signed [SEG_W-1:0]  seg_223;
      logic signed [SEG_W-1:0]  seg_224;
   } cfg_type;

   typedef struct packed {
      logic       a_223;
      logic       b_223;
      logic [1:0] c_223;
      logic       a_224;
      logic       b_224;
      logic       c_224;
      logic       d_224;
   } mix_type;

   typedef struct packed {
      logic       route_select;
      logic       autopilot_request;
      logic [1:0] hud_number;
      logic       camera_select;
      logic       menu_enter;
      logic       menu_next;
      logic       failsafe_flag;
   } result_type;

endpackage

@@ rtl/rcpsd_ifs.sv @@
// rcpsd channel interfaces: pulse input, decoded result, csr write
// depends on rcpsd_pkg

interface rcpsd_req_if;
   import rcpsd_pkg::*;
   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] pulse_width;
   logic [PULSE_W-1:0] tail_pulse_width;
   modport source (output valid, pulse_width, tail_pulse_width, input ready);
   modport sink   (input valid, pulse_width, tail_pulse_width, output ready);
endinterface

interface rcpsd_rsp_if;
   logic       valid;
   logic       ready;
   logic       route_select;
   logic       autopilot_request;
   logic [1:0] hud_number;
   logic       camera_select;
   logic       menu_enter;
   logic       menu_next;
   logic       failsafe_flag;
   modport source (output valid, route_select, autopilot_request, hud_number,
                   camera_select, menu_enter, menu_next, failsafe_flag, input ready);
   modport sink   (input valid, route_select, autopilot_request, hud_number,
                   camera_select, menu_enter, menu_next, failsafe_flag, output ready);
endinterface

interface rcpsd_csr_if;
   import rcpsd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [PULSE_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/rcpsd_cfg.sv @@
// rcpsd_cfg: configuration registers and segment width derivation
// depends on rcpsd_pkg and rcpsd_csr_if

module rcpsd_cfg (
   input  logic               clock,
   input  logic               reset,
   rcpsd_csr_if.sink          csr_chan,
   output rcpsd_pkg::cfg_type cfg
);
   import rcpsd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic [PULSE_W-1:0]      new_min, new_max;
   logic signed [PULSE_W:0] span;
   logic [PULSE_W-1:0]      mag;
   logic [63:0]             prod_223, prod_224;
   logic [SEG_W-1:0]        quot_223, quot_224;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   // segment width from the calibration as it stands after this write
   always_comb begin
      new_min = (csr_chan.valid && csr_chan.index == REG_PULSE_MIN) ?
                csr_chan.data : cfg_ff.pulse_min;
      new_max = (csr_chan.valid && csr_chan.index == REG_PULSE_MAX) ?
                csr_chan.data : cfg_ff.pulse_max;
      span = $signed({1'b0, new_max}) - $signed({1'b0, new_min});
      mag  = span[PULSE_W] ? PULSE_W'(-span) : span[PULSE_W-1:0];
      prod_223 = 64'(mag) * 64'(RECIP_223);
      prod_224 = 64'(mag) * 64'(RECIP_224);
      quot_223 = SEG_W'(prod_223 >> SHIFT_223);
      quot_224 = SEG_W'(prod_224 >> SHIFT_224);
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_DEMUX_MODE:      cfg_in.demux_mode = mode_type'(csr_chan.data[1:0]);
            REG_AUTOPILOT_AVAIL: cfg_in.autopilot_available = csr_chan.data[0];
            REG_SWITCH_THRESH:   cfg_in.switch_threshold = csr_chan.data;
            REG_PULSE_MIN:       cfg_in.pulse_min = csr_chan.data;
            REG_PULSE_MAX:       cfg_in.pulse_max = csr_chan.data;
            default:             cfg_in = cfg_ff;
         endcase
         // truncation toward zero: negate the magnitude quotient
         cfg_in.seg_223 = span[PULSE_W] ? -$signed(quot_223) : $signed(quot_223);
         cfg_in.seg_224 = span[PULSE_W] ? -$signed(quot_224) : $signed(quot_224);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.demux_mode          <= MODE_TWO_POS;
         cfg_ff.autopilot_available <= 1'b0;
         cfg_ff.switch_threshold    <= RST_SWITCH_THRESH;
         cfg_ff.pulse_min           <= RST_PULSE_MIN;
         cfg_ff.pulse_max           <= RST_PULSE_MAX;
         cfg_ff.seg_223             <= SEG_W'(RST_SEG_223);
         cfg_ff.seg_224             <= SEG_W'(RST_SEG_224);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/rcpsd_mix.sv @@
// rcpsd_mix: splits a multiplexed pulse into its 2x2x3 and 2x2x4 fields
// depends on rcpsd_pkg; purely combinational

module rcpsd_mix (
   input  logic [rcpsd_pkg::PULSE_W-1:0]      pulse_width,
   input  logic [rcpsd_pkg::PULSE_W-1:0]      pulse_min,
   input  logic signed [rcpsd_pkg::SEG_W-1:0] seg_223,
   input  logic signed [rcpsd_pkg::SEG_W-1:0] seg_224,
   output rcpsd_pkg::mix_type                 mix
);
   import rcpsd_pkg::*;

   logic signed [VAL_W-1:0] r3, r4, half3, half4, v3, v4;
   logic [NUM_MULT-1:0]     gt3, gt4;
   logic [3:0]              base3;

   // half the segment, truncated toward zero
   always_comb begin
      r3 = VAL_W'(seg_223);
      r4 = VAL_W'(seg_224);
      half3 = (r3 + $signed(VAL_W'(r3 < 0))) >>> 1;
      half4 = (r4 + $signed(VAL_W'(r4 < 0))) >>> 1;
      v3 = $signed(VAL_W'(pulse_width)) - $signed(VAL_W'(pulse_min)) + half3;
      v4 = $signed(VAL_W'(pulse_width)) - $signed(VAL_W'(pulse_min)) + half4;
   end

   // every threshold compare in parallel, the fields then pick among them
   always_comb begin
      logic signed [VAL_W-1:0] kk;
      for (int k = 0; k < NUM_MULT; k++) begin
         kk = VAL_W'(k);
         gt3[k] = v3 > r3 * kk;
         gt4[k] = v4 > r4 * kk;
      end
   end

   always_comb begin
      mix.a_223 = gt3[6];
      mix.b_223 = mix.a_223 ? gt3[9] : gt3[3];
      base3 = (mix.a_223 ? 4'd6 : 4'd0) + (mix.b_223 ? 4'd3 : 4'd0);
      if (gt3[base3 + 4'd2])
         mix.c_223 = 2'd2;
      else if (gt3[base3 + 4'd1])
         mix.c_223 = 2'd1;
      else
         mix.c_223 = 2'd0;

      mix.a_224 = gt4[8];
      mix.b_224 = gt4[{mix.a_224, 3'b100}];
      mix.c_224 = gt4[{mix.a_224, mix.b_224, 2'b10}];
      mix.d_224 = gt4[{mix.a_224, mix.b_224, mix.c_224, 1'b1}];
   end

endmodule

@@ rtl/rcpsd_core.sv @@
// rcpsd_core: input register, per-mode switch state, decode and result register
// depends on rcpsd_pkg, rcpsd_ifs and rcpsd_mix

module rcpsd_core (
   input  logic               clock,
   input  logic               reset,
   input  rcpsd_pkg::cfg_type cfg,
   rcpsd_req_if.sink          req_chan,
   rcpsd_rsp_if.source        rsp_chan
);
   import rcpsd_pkg::*;

   localparam logic [1:0] POS_LOW  = 2'd0;
   localparam logic [1:0] POS_MID  = 2'd1;
   localparam logic [1:0] POS_HIGH = 2'd2;

   logic               in_valid_ff, in_valid_in;
   logic [PULSE_W-1:0] pw_ff, pw_in, tail_ff, tail_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         res_ff, res_in;
   logic               advance;

   logic       two_pos_last_ff, two_pos_last_in;
   logic [1:0] two_pos_count_ff, two_pos_count_in;
   logic [1:0] three_pos_last_ff, three_pos_last_in;
   logic       three_pos_route_ff, three_pos_route_in;
   logic [1:0] three_pos_hud_ff, three_pos_hud_in;
   logic       mix_last_bit_ff, mix_last_bit_in;
   logic [1:0] mix_hud_ff, mix_hud_in;
   logic       camera_hold_ff, camera_hold_in;

   mix_type mix;
   logic    on, rise, avail;

   rcpsd_mix u_mix (
      .pulse_width (pw_ff),
      .pulse_min   (cfg.pulse_min),
      .seg_223     (cfg.seg_223),
      .seg_224     (cfg.seg_224),
      .mix         (mix)
   );

   // the result register frees the input register when it drains or is empty
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      pw_in       = pw_ff;
      tail_in     = tail_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         pw_in       = req_chan.pulse_width;
         tail_in     = req_chan.tail_pulse_width;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      two_pos_last_in    = two_pos_last_ff;
      two_pos_count_in   = two_pos_count_ff;
      three_pos_last_in  = three_pos_last_ff;
      three_pos_route_in = three_pos_route_ff;
      three_pos_hud_in   = three_pos_hud_ff;
      mix_last_bit_in    = mix_last_bit_ff;
      mix_hud_in         = mix_hud_ff;
      camera_hold_in     = camera_hold_ff;
      res_in             = '0;

      avail = cfg.autopilot_available;
      on    = pw_ff > cfg.switch_threshold;
      rise  = on && !two_pos_last_ff;

      unique case (cfg.demux_mode)
         MODE_TWO_POS: begin
            two_pos_last_in  = on;
            res_in.menu_enter = on;
            res_in.menu_next  = tail_ff > cfg.switch_threshold;
            if (avail) begin
               if (rise)
                  two_pos_count_in = {1'b0, ~two_pos_count_ff[0]};
               res_in.route_select      = two_pos_count_in[0];
               res_in.autopilot_request = on;
               res_in.hud_number        = 2'd1;
            end else begin
               if (rise)
                  two_pos_count_in = two_pos_count_ff + 2'd1;
               res_in.route_select = on;
               res_in.hud_number   = two_pos_count_in;
            end
         end
         MODE_THREE_POS: begin
            if (pw_ff < LOW_LIMIT) begin
               if (three_pos_last_ff != POS_LOW)
                  three_pos_route_in = ~three_pos_route_ff;
               three_pos_last_in = POS_LOW;
               res_in.menu_enter = 1'b1;
            end else if (pw_ff < HIGH_LIMIT) begin
               three_pos_last_in = POS_MID;
            end else begin
               if (three_pos_last_ff != POS_HIGH)
                  three_pos_hud_in = three_pos_hud_ff + 2'd1;
               three_pos_last_in = POS_HIGH;
               res_in.menu_next  = 1'b1;
            end
            res_in.route_select      = three_pos_route_in;
            res_in.hud_number        = three_pos_hud_in;
            res_in.autopilot_request = avail && (three_pos_last_in != POS_MID);
         end
         MODE_MIX_223: begin
            res_in.route_select = mix.a_223;
            if (avail) begin
               res_in.autopilot_request = mix.b_223;
               res_in.hud_number        = mix.c_223 + 2'd1;
            end else begin
               res_in.hud_number = mix.b_223 ? mix.c_223 + 2'd1 : 2'd0;
            end
            res_in.menu_enter = mix.c_223 == 2'd2;
            res_in.menu_next  = mix.c_223 == 2'd0;
         end
         MODE_MIX_224: begin
            if (mix_last_bit_ff != mix.d_224) begin
               mix_hud_in      = mix_hud_ff + 2'd1;
               mix_last_bit_in = mix.d_224;
            end
            camera_hold_in           = mix.c_224;
            res_in.route_select      = mix.a_224;
            res_in.hud_number        = mix_hud_in;
            res_in.autopilot_request = avail && mix.b_224;
            res_in.menu_enter        = mix.a_224;
            res_in.menu_next         = mix.b_224;
         end
         default: res_in = '0;
      endcase

      res_in.camera_select = camera_hold_in;
      res_in.failsafe_flag = {1'b0, pw_ff} > ({1'b0, cfg.pulse_max} + FAILSAFE_MARGIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         two_pos_last_ff    <= 1'b0;
         two_pos_count_ff   <= 2'd0;
         three_pos_last_ff  <= POS_LOW;
         three_pos_route_ff <= 1'b0;
         three_pos_hud_ff   <= 2'd0;
         mix_last_bit_ff    <= 1'b0;
         mix_hud_ff         <= 2'd0;
         camera_hold_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            two_pos_last_ff    <= two_pos_last_in;
            two_pos_count_ff   <= two_pos_count_in;
            three_pos_last_ff  <= three_pos_last_in;
            three_pos_route_ff <= three_pos_route_in;
            three_pos_hud_ff   <= three_pos_hud_in;
            mix_last_bit_ff    <= mix_last_bit_in;
            mix_hud_ff         <= mix_hud_in;
            camera_hold_ff     <= camera_hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      pw_ff   <= pw_in;
      tail_ff <= tail_in;
      if (advance)
         res_ff <= res_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.route_select      = res_ff.route_select;
   assign rsp_chan.autopilot_request = res_ff.autopilot_request;
   assign rsp_chan.hud_number        = res_ff.hud_number;
   assign rsp_chan.camera_select     = res_ff.camera_select;
   assign rsp_chan.menu_enter        = res_ff.menu_enter;
   assign rsp_chan.menu_next         = res_ff.menu_next;
   assign rsp_chan.failsafe_flag     = res_ff.failsafe_flag;

endmodule

@@ rtl/rc_pulse_switch_demux.sv @@
// rc_pulse_switch_demux: top level of the rc pulse switch decoder
// depends on rcpsd_pkg, rcpsd_ifs, rcpsd_cfg and rcpsd_core
//
//   channel    direction  handshake     payload
//   req_chan   in         valid/ready   pulse_width, tail_pulse_width
//   rsp_chan   out        valid/ready   route_select .. failsafe_flag
//   csr_chan   in         valid/ready   index, data (always ready)
//
// an item is registered on accept in the input register and decoded into the
// result register, which drives rsp_chan, once that register is empty or
// drains; one item per cycle sustained while rsp_chan is ready. the input
// register refills in the same cycle that its item moves into the result
// register, so a stalled rsp_chan holds at most two items before req_chan
// drops ready. reset clears the valid flags, the switch state and loads the
// register defaults.

module rc_pulse_switch_demux (
   input  logic        clock,
   input  logic        reset,
   rcpsd_req_if.sink   req_chan,
   rcpsd_rsp_if.source rsp_chan,
   rcpsd_csr_if.sink   csr_chan
);
   import rcpsd_pkg::*;

   cfg_type cfg;

   rcpsd_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   rcpsd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
